// ===== hdl/ipid_pkg.sv =====
// types and constants shared by the incremental pid controller
// depends on nothing; imported by ipid_datapath and incremental_pid_controller
package ipid_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_SPAN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_FF   = 3'd5;
    localparam int unsigned CFG_DATA_W = 32;

    // reset values of the configuration registers
    localparam logic signed [31:0] COEF_A_RST   = 32'sd65536;
    localparam logic signed [31:0] COEF_B_RST   = 32'sd65536;
    localparam logic signed [31:0] COEF_C_RST   = 32'sd0;
    localparam logic signed [15:0] OUT_MIN_RST  = 16'sd0;
    localparam logic        [15:0] OUT_SPAN_RST = 16'd1023;

    // one input sample
    typedef struct packed {
        logic signed [15:0] setpoint;
        logic signed [15:0] measurement;
        logic signed [15:0] ff_bias;
        logic               auto_mode;
        logic signed [15:0] manual_output;
    } t_in_item;

    // one result
    typedef struct packed {
        logic signed [16:0] drive;
        logic               computed;
    } t_out_item;

    // configuration register file
    typedef struct packed {
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
        logic signed [15:0] out_min;
        logic        [15:0] out_span;
        logic               use_feedforward;
    } t_cfg;

    // controller state carried from sample to sample
    typedef struct packed {
        logic signed [16:0] last_error;
        logic signed [16:0] prior_error;
        logic signed [17:0] bias_value;
        logic               was_auto;
    } t_state;

endpackage

// ===== hdl/incremental_pid_controller.sv =====
// top level of the incremental pid controller: handshakes, registers, state
// depends on ipid_pkg and ipid_datapath
//
// Usage:
//   Samples enter on the input channel (i_in_valid / o_in_ready, payload
//   i_in_data) and results leave on the output channel (o_out_valid /
//   i_out_ready, payload o_out_data). Each sample gives exactly one result.
//   A sample is held in an input register; once the result register is free
//   or being read, the products, sum, shift and clamp are computed and
//   written to the result register together with the updated error history
//   and bias. One sample per cycle is sustained while the receiver keeps
//   taking results.
//   When the receiver stalls, the result register holds and the input
//   register can still take one more sample; after that o_in_ready drops.
//   Config is written via i_cfg_we / i_cfg_idx / i_cfg_wdata with no wait; the
//   user must write only while no sample is in flight; the block won't check.
//   Reset clears both registers' valid flags, zeroes the error history and
//   bias, marks the controller as in auto mode and loads the register
//   defaults. No clearing pass is needed.
module incremental_pid_controller
    import ipid_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    t_in_item  r_in_data;
    logic      r_in_vld;
    t_out_item r_out_data;
    t_out_item n_out_data;
    logic      r_out_vld;
    logic      adv;
    logic      in_xfer;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_a          <= COEF_A_RST;
            r_cfg.coef_b          <= COEF_B_RST;
            r_cfg.coef_c          <= COEF_C_RST;
            r_cfg.out_min         <= OUT_MIN_RST;
            r_cfg.out_span        <= OUT_SPAN_RST;
            r_cfg.use_feedforward <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COEF_A:   r_cfg.coef_a          <= $signed(i_cfg_wdata);
                CFG_COEF_B:   r_cfg.coef_b          <= $signed(i_cfg_wdata);
                CFG_COEF_C:   r_cfg.coef_c          <= $signed(i_cfg_wdata);
                CFG_OUT_MIN:  r_cfg.out_min         <= $signed(i_cfg_wdata[15:0]);
                CFG_OUT_SPAN: r_cfg.out_span        <= i_cfg_wdata[15:0];
                CFG_USE_FF:   r_cfg.use_feedforward <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // handshake control
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;
    assign in_xfer    = i_in_valid && o_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_data <= i_in_data;
        end
    end

    // arithmetic for the sample in the input register
    ipid_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_item   (r_in_data),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_result (n_out_data),
        .o_state  (n_state)
    );

    // controller state, updated as each sample moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_error  <= '0;
            r_state.prior_error <= '0;
            r_state.bias_value  <= '0;
            r_state.was_auto    <= 1'b1;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    // computed results stay inside the span
    a_drive_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_data.computed) |->
            (r_out_data.drive <= $signed({1'b0, r_cfg.out_span})) &&
            (r_out_data.drive >= -$signed({1'b0, r_cfg.out_span})))
        else $error("computed drive outside span");

    // a manual sample is echoed unchanged
    a_manual_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_in_data.auto_mode) |=>
            (r_out_vld && !r_out_data.computed &&
             r_out_data.drive == $past(r_in_data.manual_output)))
        else $error("manual sample not echoed");

    // a manual sample leaves the controller out of auto mode
    a_manual_clears_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_in_data.auto_mode) |=> !r_state.was_auto)
        else $error("auto flag not cleared by manual sample");

    // input stalls only when both registers are full and the receiver waits
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_vld && r_out_vld && !i_out_ready))
        else $error("input stalled without cause");

endmodule

// ===== hdl/ipid_datapath.sv =====
// single-pass velocity-form pid arithmetic: error, three products, shift, clamp
// depends on ipid_pkg; instantiated by incremental_pid_controller
module ipid_datapath
    import ipid_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    input  t_state    i_state,
    output t_out_item o_result,
    output t_state    o_state
);

    localparam int unsigned PROD_W = 49;              // 32 x 17 signed
    localparam int unsigned ACC_W  = PROD_W + 2;      // sum of three products
    localparam int unsigned SH_W   = ACC_W - FRAC_BITS;
    localparam int unsigned RES_W  = SH_W + 1;        // shifted sum plus 18-bit bias

    logic signed [16:0]       err;
    logic signed [17:0]       ff_off;
    logic signed [17:0]       man_off;
    logic signed [17:0]       bias;
    logic signed [PROD_W-1:0] prod_a;
    logic signed [PROD_W-1:0] prod_b;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [ACC_W-1:0]  acc;
    logic signed [SH_W-1:0]   acc_sh;
    logic signed [RES_W-1:0]  res;
    logic signed [RES_W-1:0]  span_pos;
    logic signed [RES_W-1:0]  span_neg;
    logic signed [16:0]       clamped;

    // error and bias selection
    assign err     = 17'(i_item.setpoint) - 17'(i_item.measurement);
    assign ff_off  = 18'(i_item.ff_bias) - 18'(i_cfg.out_min);
    assign man_off = 18'(i_item.manual_output) - 18'(i_cfg.out_min);

    always_comb begin
        if (i_cfg.use_feedforward) begin
            bias = ff_off;
        end else if (!i_state.was_auto) begin
            bias = man_off;
        end else begin
            bias = i_state.bias_value;
        end
    end

    // three products, combined as a minus b plus c
    assign prod_a = PROD_W'(i_cfg.coef_a) * PROD_W'(err);
    assign prod_b = PROD_W'(i_cfg.coef_b) * PROD_W'(i_state.last_error);
    assign prod_c = PROD_W'(i_cfg.coef_c) * PROD_W'(i_state.prior_error);
    assign acc    = ACC_W'(prod_a) - ACC_W'(prod_b) + ACC_W'(prod_c);

    // arithmetic shift rounds toward minus infinity
    assign acc_sh = $signed(acc[ACC_W-1:FRAC_BITS]);
    assign res    = RES_W'(bias) + RES_W'(acc_sh);

    // saturate to plus or minus the span
    assign span_pos = RES_W'($signed({1'b0, i_cfg.out_span}));
    assign span_neg = -span_pos;

    always_comb begin
        if (res < span_neg) begin
            clamped = span_neg[16:0];
        end else if (res > span_pos) begin
            clamped = span_pos[16:0];
        end else begin
            clamped = res[16:0];
        end
    end

    // result and next state, manual samples only clear the auto flag
    always_comb begin
        o_state = i_state;
        if (i_item.auto_mode) begin
            o_result.drive       = clamped;
            o_result.computed    = 1'b1;
            o_state.prior_error  = i_state.last_error;
            o_state.last_error   = err;
            o_state.bias_value   = i_cfg.use_feedforward ? bias : 18'(clamped);
            o_state.was_auto     = 1'b1;
        end else begin
            o_result.drive       = 17'(i_item.manual_output);
            o_result.computed    = 1'b0;
            o_state.was_auto     = 1'b0;
        end
    end

endmodule

// ===== dv/incremental_pid_controller_tb.sv =====
// self-checking testbench for the incremental pid controller
// predicts every result in-line, compares the results with a queue, drives random idle gaps
// depends on ipid_pkg and the incremental_pid_controller rtl
`timescale 1ns / 1ps

module incremental_pid_controller_tb;
    import ipid_pkg::*;

    localparam int unsigned FRAC = 16;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned ITEMS_PER_PHASE = 134;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // idle percentages of the sender and the receiver
    int unsigned send_idle_pct = 16;
    int unsigned recv_idle_pct = 54;

    int unsigned cycles = 0;
    int unsigned mismatches = 0;
    int unsigned samples_sent = 0;
    int unsigned results_checked = 0;
    int unsigned reg_writes = 0;

    // expected results in transfer order
    t_out_item expected_drives[$];

    // predictor copy of the registers and controller state
    logic signed [31:0] p_coef_a = COEF_A_RST;
    logic signed [31:0] p_coef_b = COEF_B_RST;
    logic signed [31:0] p_coef_c = COEF_C_RST;
    logic signed [15:0] p_out_min = OUT_MIN_RST;
    logic        [15:0] p_out_span = OUT_SPAN_RST;
    logic               p_use_ff = 1'b0;
    logic signed [16:0] p_last_err = '0;
    logic signed [16:0] p_prior_err = '0;
    logic signed [17:0] p_bias = '0;
    logic               p_was_auto = 1'b1;

    incremental_pid_controller #(
        .FRAC_BITS(FRAC)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data(out_data),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    // clock
    initial begin
        forever #2 clk = ~clk;
    end

    // watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver stalls
    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // velocity-form pid step: updates the predictor state, returns the expected result
    function automatic t_out_item predict_drive(input t_in_item s);
        t_out_item r;
        longint sp, meas, ff, man, err, acc, res, span, bias;
        sp = $signed(s.setpoint);
        meas = $signed(s.measurement);
        ff = $signed(s.ff_bias);
        man = $signed(s.manual_output);
        // manual passthrough leaves history and bias alone
        if (!s.auto_mode) begin
            p_was_auto = 1'b0;
            r.drive = man[16:0];
            r.computed = 1'b0;
            return r;
        end
        // bumpless reload on the manual to auto change
        if (!p_was_auto) begin
            bias = (p_use_ff ? ff : man) - longint'($signed(p_out_min));
            p_bias = bias[17:0];
        end
        p_was_auto = 1'b1;
        err = sp - meas;
        if (p_use_ff) begin
            bias = ff - longint'($signed(p_out_min));
            p_bias = bias[17:0];
        end
        acc = longint'($signed(p_coef_a)) * err
            - longint'($signed(p_coef_b)) * longint'($signed(p_last_err))
            + longint'($signed(p_coef_c)) * longint'($signed(p_prior_err));
        res = longint'($signed(p_bias)) + (acc >>> FRAC);
        span = p_out_span;
        if (res < -span) res = -span;
        else if (res > span) res = span;
        p_prior_err = p_last_err;
        p_last_err = err[16:0];
        if (!p_use_ff) p_bias = res[17:0];
        r.drive = res[16:0];
        r.computed = 1'b1;
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatches < 10) $display("mismatch: %s", what);
        mismatches++;
    endtask

    // result checker
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_drives.size() == 0) begin
                flag_mismatch($sformatf("unexpected result drive %0d computed %0b",
                    $signed(out_data.drive), out_data.computed));
            end else begin
                want = expected_drives.pop_front();
                results_checked++;
                if (out_data.drive !== want.drive)
                    flag_mismatch($sformatf("result %0d drive expected %0d actual %0d",
                        results_checked, $signed(want.drive), $signed(out_data.drive)));
                if (out_data.computed !== want.computed)
                    flag_mismatch($sformatf("result %0d computed expected %0b actual %0b",
                        results_checked, want.computed, out_data.computed));
            end
        end
    end

    // one sample transfer; valid stays high afterwards until the next call or a drain
    task automatic send_sample(input t_in_item s);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= s;
        do @(posedge clk); while (!in_ready);
        expected_drives.push_back(predict_drive(s));
        samples_sent++;
    endtask

    // stop sending and wait for every result to come back
    task automatic drain;
        in_valid <= 1'b0;
        while (expected_drives.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write, only while idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        reg_writes++;
        case (idx)
            CFG_COEF_A:   p_coef_a = val;
            CFG_COEF_B:   p_coef_b = val;
            CFG_COEF_C:   p_coef_c = val;
            CFG_OUT_MIN:  p_out_min = val[15:0];
            CFG_OUT_SPAN: p_out_span = val[15:0];
            CFG_USE_FF:   p_use_ff = val[0];
            default:      ;
        endcase
    endtask

    function automatic t_in_item make_sample(input int sp, input int meas, input int ff,
                                             input bit auto_on, input int man);
        t_in_item s;
        s.setpoint = sp[15:0];
        s.measurement = meas[15:0];
        s.ff_bias = ff[15:0];
        s.auto_mode = auto_on;
        s.manual_output = man[15:0];
        return s;
    endfunction

    // random sample: mostly auto, errors often small so the loop leaves saturation
    function automatic t_in_item random_sample;
        t_in_item s;
        s.setpoint = 16'($urandom);
        if ($urandom_range(0, 1))
            s.measurement = s.setpoint + 16'($signed($urandom_range(0, 600)) - 300);
        else
            s.measurement = 16'($urandom);
        s.ff_bias = 16'($urandom);
        s.auto_mode = ($urandom_range(0, 99) >= 12);
        s.manual_output = 16'($urandom);
        return s;
    endfunction

    function automatic logic [31:0] random_coef;
        logic [31:0] c;
        if ($urandom_range(0, 3) == 0) begin
            c = $urandom;
        end else begin
            c = $urandom_range(0, 4 * 65536);
            if ($urandom_range(0, 1)) c = -c;
        end
        return c;
    endfunction

    task automatic random_config;
        write_reg(CFG_COEF_A, random_coef());
        write_reg(CFG_COEF_B, random_coef());
        write_reg(CFG_COEF_C, random_coef());
        write_reg(CFG_OUT_MIN, $urandom);
        if ($urandom_range(0, 1))
            write_reg(CFG_OUT_SPAN, $urandom_range(1, 65535));
        else
            write_reg(CFG_OUT_SPAN, $urandom_range(1, 2000));
        write_reg(CFG_USE_FF, $urandom);
    endtask

    // register defaults with the widest errors
    task automatic test_default_regs;
        send_sample(make_sample(32767, -32768, 0, 1, 0));
        send_sample(make_sample(-32768, 32767, 0, 1, 0));
        send_sample(make_sample(0, 0, 0, 1, 0));
        send_sample(make_sample(100, 40, 0, 1, 0));
    endtask

    // manual passthrough and the reload from the manual output
    task automatic test_manual_mode;
        send_sample(make_sample(1234, -99, 77, 0, 32767));
        send_sample(make_sample(-5, 5, -77, 0, -32768));
        send_sample(make_sample(0, 0, 0, 0, 0));
        send_sample(make_sample(10, 5, -300, 1, 500));
    endtask

    // feed-forward bias with both out_min extremes, reload from the feed-forward value
    task automatic test_feedforward;
        drain();
        write_reg(CFG_USE_FF, 1);
        write_reg(CFG_OUT_MIN, 32'hFFFF_8000);
        send_sample(make_sample(3, 1, 32767, 1, -1));
        drain();
        write_reg(CFG_OUT_MIN, 32767);
        send_sample(make_sample(-3, 1, -32768, 1, 1));
        send_sample(make_sample(0, 0, 0, 0, 4321));
        send_sample(make_sample(20, -20, 1000, 1, -4321));
        drain();
        write_reg(CFG_USE_FF, 0);
        write_reg(CFG_OUT_MIN, 0);
    endtask

    // widest, narrowest and zero span
    task automatic test_output_span;
        drain();
        write_reg(CFG_OUT_SPAN, 65535);
        write_reg(CFG_COEF_A, 32'h0002_0000);
        send_sample(make_sample(32767, -32768, 0, 1, 0));
        drain();
        write_reg(CFG_OUT_SPAN, 1);
        send_sample(make_sample(-200, 100, 0, 1, 0));
        drain();
        write_reg(CFG_OUT_SPAN, 0);
        send_sample(make_sample(500, 0, 0, 1, 0));
        send_sample(make_sample(-500, 0, 0, 1, 0));
    endtask

    // coefficient extremes against the widest error history
    task automatic test_coef_extremes;
        drain();
        write_reg(CFG_OUT_SPAN, 65535);
        write_reg(CFG_COEF_A, 32'h7FFF_FFFF);
        write_reg(CFG_COEF_B, 32'h8000_0000);
        write_reg(CFG_COEF_C, 32'h7FFF_FFFF);
        send_sample(make_sample(32767, -32768, 0, 1, 0));
        send_sample(make_sample(-32768, 32767, 0, 1, 0));
        drain();
        write_reg(CFG_COEF_A, 32'h8000_0000);
        write_reg(CFG_COEF_B, 32'h7FFF_FFFF);
        write_reg(CFG_COEF_C, 32'h8000_0000);
        send_sample(make_sample(32767, -32768, 0, 1, 0));
        send_sample(make_sample(1, 0, 0, 1, 0));
    endtask

    // writes to indexes past the register list change nothing
    task automatic test_unused_index;
        drain();
        write_reg(CFG_UNUSED_LO, $urandom);
        write_reg(CFG_UNUSED_HI, $urandom);
        write_reg(CFG_UNUSED_LO, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED_HI, 32'h0000_0000);
        send_sample(make_sample(700, 100, 5, 1, 9));
        send_sample(make_sample(-700, 100, 5, 1, 9));
    endtask

    // random samples under three idling mixes, new registers per phase
    task automatic test_random_traffic;
        for (int phase = 0; phase < 3; phase++) begin
            drain();
            case (phase)
                0: begin send_idle_pct = 16; recv_idle_pct = 54; end
                1: begin send_idle_pct = 54; recv_idle_pct = 16; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            random_config();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_sample(random_sample());
                // occasional mid-phase retune
                if (n == ITEMS_PER_PHASE / 2) begin
                    drain();
                    random_config();
                end
            end
        end
    endtask

    // main sequence
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_regs();
        test_manual_mode();
        test_feedforward();
        test_output_span();
        test_coef_extremes();
        test_unused_index();
        test_random_traffic();
        drain();
        repeat (8) @(posedge clk);
        if (expected_drives.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_drives.size()));
        $display("sent %0d samples and checked %0d results across %0d register writes",
            samples_sent, results_checked, reg_writes);
        $display("covered manual/auto changes, feed-forward, span and coefficient extremes");
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
